// ===== design/assert_macros.svh =====
// Assertion macros shared by the property record scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked property, disabled while reset is asserted (active low).
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property, evaluated during reset as well.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ===== design/prscan_pkg.sv =====
// Shared types and constants for the property record scanner.
package prscan_pkg;

    localparam logic [7:0] CMD_SET_PROPERTY = 8'h11;
    localparam logic [7:0] MIN_SET_LEN      = 8'h05;
    localparam logic [7:0] MAX_SET_LEN      = 8'h10;
    localparam logic [8:0] HEADER_EXTRA     = 9'd4;
    localparam logic [8:0] VALUE_OFFSET     = 9'd5;

    typedef enum logic [1:0] {
        STATUS_NOT_FOUND = 2'd0,
        STATUS_FOUND     = 2'd1,
        STATUS_MALFORMED = 2'd2
    } status_t;

    typedef enum logic {
        REG_TARGET_GROUP   = 1'b0,
        REG_TARGET_ADDRESS = 1'b1
    } cfg_reg_t;

endpackage

// ===== design/property_record_scanner_core.sv =====
// Property record scanner: byte-serial parser for arrays of length-prefixed command records.
//
// One byte per cycle is taken on s_ while s_ready is high; s_array_start marks the
// first byte of an array and restarts the scan. Each record is a length byte L
// followed by L bytes, the first being the command byte; a zero length byte where
// a record begins ends the array. Only set-property records (command 0x11) are
// parsed: L, 0x11, group, count, start, then count value bytes, with L in 5..16
// and L equal to count + 4. When group equals target_group and target_address
// lies in [start, start + count) the value at that offset is captured; later hits
// overwrite earlier ones. At the end of the array, or on a malformed set-property
// record, one result request goes out on the m_ channel (status 0 not found,
// 1 found, 2 malformed; value is zero unless found) and bytes are then ignored
// until the next array start.
// Throughput is one byte per cycle, but for the stall on a second result below. A byte
// is captured in the input register, where the parser state and the result are
// worked out from it, and a result request is then raised on m_valid from the
// result register. The result register and the input register together let bytes
// that give no result keep flowing while a result request waits on m_ready; a byte
// that would give a second result waits in the input register until the first is
// taken.
// Configuration: cfg_wr_en with cfg_index 0 writes target_group, index 1 writes
// target_address; write only while no array is being scanned.
module property_record_scanner_core
    import prscan_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wr_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_array_start,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_property_value
);

`include "assert_macros.svh"

    // Configuration registers
    logic [7:0] target_group_reg;
    logic [7:0] target_address_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Parser state
    logic       scan_active_reg,     scan_active_next;
    logic [7:0] byte_position_reg,   byte_position_next;
    logic [7:0] record_length_reg,   record_length_next;
    logic       is_set_property_reg, is_set_property_next;
    logic       group_matches_reg,   group_matches_next;
    logic [7:0] value_count_reg,     value_count_next;
    logic [8:0] wanted_position_reg, wanted_position_next;
    logic       match_pending_reg,   match_pending_next;
    logic       found_flag_reg,      found_flag_next;
    logic [7:0] latched_value_reg,   latched_value_next;

    // Result register
    logic       m_valid_reg;
    status_t    m_status_reg;
    logic [7:0] m_value_reg;

    // Result produced by the byte in the input register
    logic       res_valid;
    status_t    res_status;
    logic [7:0] res_value;

    logic       advance;
    logic [8:0] range_end;   // start + count, never wraps
    logic [8:0] len_expect;  // count + 4

    // The input stage moves on unless it would overwrite a result still waiting.
    assign advance = in_valid_reg && (!res_valid || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign range_end  = {1'b0, value_count_next} + {1'b0, in_byte_reg};
    assign len_expect = {1'b0, in_byte_reg} + HEADER_EXTRA;

    // Parser next state. Note value_count_next is final before range_end is used:
    // the start byte comes one record position after the count byte.
    always_comb begin
        scan_active_next     = scan_active_reg;
        byte_position_next   = byte_position_reg;
        record_length_next   = record_length_reg;
        is_set_property_next = is_set_property_reg;
        group_matches_next   = group_matches_reg;
        value_count_next     = value_count_reg;
        wanted_position_next = wanted_position_reg;
        match_pending_next   = match_pending_reg;
        found_flag_next      = found_flag_reg;
        latched_value_next   = latched_value_reg;
        res_valid            = 1'b0;
        res_status           = STATUS_NOT_FOUND;
        res_value            = 8'd0;

        // array start wipes the scan and opens a new one
        if (in_start_reg) begin
            scan_active_next     = 1'b1;
            byte_position_next   = 8'd0;
            record_length_next   = 8'd0;
            is_set_property_next = 1'b0;
            group_matches_next   = 1'b0;
            value_count_next     = 8'd0;
            wanted_position_next = 9'd0;
            match_pending_next   = 1'b0;
            found_flag_next      = 1'b0;
            latched_value_next   = 8'd0;
        end

        if (scan_active_next) begin
            if (byte_position_next == 8'd0) begin
                if (in_byte_reg == 8'd0) begin
                    // terminator
                    res_valid        = 1'b1;
                    res_status       = found_flag_next ? STATUS_FOUND : STATUS_NOT_FOUND;
                    res_value        = found_flag_next ? latched_value_next : 8'd0;
                    scan_active_next = 1'b0;
                end else begin
                    record_length_next   = in_byte_reg;
                    is_set_property_next = 1'b0;
                    group_matches_next   = 1'b0;
                    match_pending_next   = 1'b0;
                    byte_position_next   = 8'd1;
                end
            end else begin
                if (byte_position_next == 8'd1) begin
                    is_set_property_next = (in_byte_reg == CMD_SET_PROPERTY);
                    if (is_set_property_next && (record_length_next < MIN_SET_LEN ||
                                                 record_length_next > MAX_SET_LEN)) begin
                        res_valid  = 1'b1;
                        res_status = STATUS_MALFORMED;
                    end
                end else if (is_set_property_next) begin
                    if (byte_position_next == 8'd2) begin
                        group_matches_next = (in_byte_reg == target_group_reg);
                    end else if (byte_position_next == 8'd3) begin
                        value_count_next = in_byte_reg;
                        if ({1'b0, record_length_next} != len_expect) begin
                            res_valid  = 1'b1;
                            res_status = STATUS_MALFORMED;
                        end
                    end else if (byte_position_next == 8'd4) begin
                        if (group_matches_next && in_byte_reg <= target_address_reg &&
                            {1'b0, target_address_reg} < range_end) begin
                            wanted_position_next = VALUE_OFFSET +
                                {1'b0, target_address_reg - in_byte_reg};
                            match_pending_next   = 1'b1;
                        end
                    end else if (match_pending_next &&
                                 {1'b0, byte_position_next} == wanted_position_next) begin
                        latched_value_next = in_byte_reg;
                        found_flag_next    = 1'b1;
                        match_pending_next = 1'b0;
                    end
                end

                if (res_valid) begin
                    scan_active_next = 1'b0;
                end else if (byte_position_next >= record_length_next) begin
                    byte_position_next = 8'd0;
                end else begin
                    byte_position_next = byte_position_next + 8'd1;
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_group_reg   <= 8'd0;
            target_address_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TARGET_GROUP:   target_group_reg   <= cfg_wr_data;
                REG_TARGET_ADDRESS: target_address_reg <= cfg_wr_data;
                default:            target_group_reg   <= target_group_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_array_start;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_active_reg     <= 1'b0;
            byte_position_reg   <= 8'd0;
            record_length_reg   <= 8'd0;
            is_set_property_reg <= 1'b0;
            group_matches_reg   <= 1'b0;
            value_count_reg     <= 8'd0;
            wanted_position_reg <= 9'd0;
            match_pending_reg   <= 1'b0;
            found_flag_reg      <= 1'b0;
            latched_value_reg   <= 8'd0;
        end else if (advance) begin
            scan_active_reg     <= scan_active_next;
            byte_position_reg   <= byte_position_next;
            record_length_reg   <= record_length_next;
            is_set_property_reg <= is_set_property_next;
            group_matches_reg   <= group_matches_next;
            value_count_reg     <= value_count_next;
            wanted_position_reg <= wanted_position_next;
            match_pending_reg   <= match_pending_next;
            found_flag_reg      <= found_flag_next;
            latched_value_reg   <= latched_value_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_status_reg <= res_status;
            m_value_reg  <= res_value;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_property_value = m_value_reg;

    // Checks
    `ASSERT_CLK_RST(a_result_ends_scan, aclk, aresetn,
        (advance && res_valid) |=> !scan_active_reg,
        "scan still active after a result request")
    `ASSERT_CLK_RST(a_value_zero_unless_found, aclk, aresetn,
        (m_valid_reg && m_status_reg != STATUS_FOUND) |-> m_value_reg == 8'd0,
        "non-zero value on a not-found or malformed result")
    `ASSERT_CLK_RST(a_pending_needs_group, aclk, aresetn,
        match_pending_reg |-> (is_set_property_reg && group_matches_reg),
        "match pending outside a matching set-property record")
    `ASSERT_CLK_RST(a_wanted_in_range, aclk, aresetn,
        match_pending_reg |-> (wanted_position_reg >= VALUE_OFFSET &&
                               wanted_position_reg <= 9'd260),
        "wanted position outside the value bytes")
    `ASSERT_CLK_RST(a_stalled_byte_held, aclk, aresetn,
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)),
        "input register changed while stalled")

endmodule
